FILE: rtl/arff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arff_pkg;

    localparam logic CMD_EXT = 1'b0;
    localparam logic CMD_INT = 1'b1;

    typedef struct packed {
        logic signed [31:0] vxl;
        logic signed [31:0] vyl;
        logic signed [31:0] pl;
        logic [30:0]        cl;
        logic [30:0]        rhol;
        logic signed [31:0] vxr;
        logic signed [31:0] vyr;
        logic signed [31:0] pr;
        logic [30:0]        cr;
        logic [30:0]        rhor;
        logic [17:0]        nx;
        logic [17:0]        ny;
        logic [30:0]        sc;
    } t_pt;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fp;
        logic               fault;
    } t_res;

    localparam int PT_W  = $bits(t_pt);
    localparam int RES_W = $bits(t_res);

    typedef enum logic [5:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_CHK,
        ST_M8, ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_M14,
        ST_D0, ST_D1, ST_D1W, ST_C0, ST_C1, ST_C2,
        ST_X0, ST_X1, ST_X2, ST_X3, ST_X4,
        ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_Y4,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_RHOL, OP_CL, OP_RHOR, OP_CR, OP_VXL, OP_VYL, OP_VXR, OP_VYR,
        OP_NX, OP_NY, OP_ZL, OP_ZR, OP_UNL, OP_UNR, OP_PL, OP_PR,
        OP_T, OP_DUN, OP_US, OP_PS, OP_Q, OP_RHOAVG, OP_C2, OP_SC
    } t_opnd;

    typedef enum logic [4:0] {
        WB_NONE, WB_ZL, WB_ZR, WB_T, WB_UNL, WB_UNR, WB_ACC, WB_UNNUM,
        WB_ACCADD, WB_PNUM, WB_C2, WB_FX, WB_FY, WB_FP, WB_US, WB_PS,
        WB_Q, WB_FAULT
    } t_wb;

    typedef enum logic [1:0] {
        DN_UNNUM, DN_PNUM, DN_T
    } t_dnum;

    typedef struct packed {
        t_opnd a_sel;
        t_opnd b_sel;
        t_wb   wb;
        logic  div_go;
        t_dnum dn_sel;
        logic  dd_rho;
        logic  pop;
        logic  push;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/arff_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module arff_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/arff_front.sv
`timescale 1ns / 1ps
`default_nettype none

module arff_front
    import arff_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic signed [31:0] i_pressure,
    input  wire logic [30:0]        i_sound_speed,
    input  wire logic [30:0]        i_density,
    input  wire logic signed [17:0] i_normal_x,
    input  wire logic signed [17:0] i_normal_y,
    input  wire logic [30:0]        i_face_scale,
    input  wire logic               i_q_full,
    output logic                    o_enq,
    output t_pt                     o_pt
);

    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic signed [31:0] r_p;
    logic [30:0]        r_c;
    logic [30:0]        r_rho;
    logic               acc;

    assign o_full = i_q_full;
    assign acc    = i_push && !i_q_full;
    assign o_enq  = acc && (i_command == CMD_INT);

    // exterior state, held until the next store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx  <= '0;
            r_vy  <= '0;
            r_p   <= '0;
            r_c   <= '0;
            r_rho <= '0;
        end else if (acc && (i_command == CMD_EXT)) begin
            r_vx  <= i_vel_x;
            r_vy  <= i_vel_y;
            r_p   <= i_pressure;
            r_c   <= i_sound_speed;
            r_rho <= i_density;
        end
    end

    always_comb begin
        o_pt.vxl  = i_vel_x;
        o_pt.vyl  = i_vel_y;
        o_pt.pl   = i_pressure;
        o_pt.cl   = i_sound_speed;
        o_pt.rhol = i_density;
        o_pt.vxr  = r_vx;
        o_pt.vyr  = r_vy;
        o_pt.pr   = r_p;
        o_pt.cr   = r_c;
        o_pt.rhor = r_rho;
        o_pt.nx   = i_normal_x;
        o_pt.ny   = i_normal_y;
        o_pt.sc   = i_face_scale;
    end

endmodule

`default_nettype wire

FILE: rtl/arff_div.sv
`timescale 1ns / 1ps
`default_nettype none

module arff_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic [30:0]        i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_q
);

    localparam int XW = 33 + FRAC_BITS;
    localparam int QB = 33;
    localparam int CW = $clog2(QB + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [QB-1:0] r_x;
    logic [QB-1:0] r_q;
    logic [30:0]   r_d;
    logic          r_neg;
    logic signed [31:0] r_qo;

    logic [31:0]   n_mag;
    logic [XW-1:0] x;
    logic          ovf;
    logic [32:0]   rem2;
    logic          ge;
    logic [32:0]   rem_n;
    logic [QB-1:0] qf;

    function automatic logic signed [31:0] satq(logic [QB-1:0] m, logic neg);
        logic signed [31:0] v;
        if (neg) begin
            v = (m > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
        end else begin
            v = (m > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
        end
        return v;
    endfunction

    // rounded dividend: |n| << frac plus half the divisor
    assign n_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign x     = (XW'(n_mag) << FRAC_BITS) + XW'(i_den[30:1]);
    assign ovf   = 64'(x) >= {i_den, 33'b0};
    assign rem2  = {r_rem, r_x[QB-1]};
    assign ge    = rem2 >= 33'(r_d);
    assign rem_n = ge ? rem2 - 33'(r_d) : rem2;
    assign qf    = {r_q[QB-2:0], ge};

    assign o_done = r_done;
    assign o_q    = r_qo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[31];
                r_d   <= i_den;
                r_x   <= x[QB-1:0];
                r_rem <= 32'(x[XW-1:QB]);
                r_q   <= '0;
                r_cnt <= CW'(QB);
                if (ovf) begin
                    r_qo   <= satq('1, i_num[31]);
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= rem_n[31:0];
                r_x   <= {r_x[QB-2:0], 1'b0};
                r_q   <= qf;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_qo   <= satq(qf, r_neg);
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/arff_back.sv
`timescale 1ns / 1ps
`default_nettype none

module arff_back
    import arff_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_pt  i_pt,
    output logic      o_pop,
    input  wire logic i_out_full,
    output logic      o_push,
    output t_res      o_res
);

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    t_pt                r_pt;
    logic signed [31:0] r_zl, r_zr, r_t, r_unl, r_unr;
    logic signed [33:0] r_acc;
    logic signed [31:0] r_unnum, r_pnum, r_us, r_ps, r_q, r_c2;
    logic signed [31:0] r_fx, r_fy, r_fp;
    logic               r_fault;
    logic [63:0]        r_p;
    logic               r_pneg;

    logic signed [31:0] m;
    logic signed [31:0] a_v, b_v;
    logic [31:0]        ma, mb;
    logic [63:0]        prod;
    logic signed [31:0] dp, dun;
    logic [31:0]        rsum;
    logic [30:0]        rho_avg;
    logic [32:0]        zs;
    logic [30:0]        den;
    logic               fault;
    logic [32:0]        cs;
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] div_n;
    logic [30:0]        div_d;

    function automatic logic signed [31:0] sat34(logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rnd(logic [63:0] p, logic neg);
        logic [63:0]        t;
        logic signed [31:0] r;
        t = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg) begin
            r = (t > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(t[31:0]);
        end else begin
            r = (t > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(t[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] pick(t_opnd s);
        logic signed [31:0] v;
        unique case (s)
            OP_RHOL:   v = $signed({1'b0, r_pt.rhol});
            OP_CL:     v = $signed({1'b0, r_pt.cl});
            OP_RHOR:   v = $signed({1'b0, r_pt.rhor});
            OP_CR:     v = $signed({1'b0, r_pt.cr});
            OP_VXL:    v = r_pt.vxl;
            OP_VYL:    v = r_pt.vyl;
            OP_VXR:    v = r_pt.vxr;
            OP_VYR:    v = r_pt.vyr;
            OP_NX:     v = $signed({{14{r_pt.nx[17]}}, r_pt.nx});
            OP_NY:     v = $signed({{14{r_pt.ny[17]}}, r_pt.ny});
            OP_ZL:     v = r_zl;
            OP_ZR:     v = r_zr;
            OP_UNL:    v = r_unl;
            OP_UNR:    v = r_unr;
            OP_PL:     v = r_pt.pl;
            OP_PR:     v = r_pt.pr;
            OP_T:      v = r_t;
            OP_DUN:    v = dun;
            OP_US:     v = r_us;
            OP_PS:     v = r_ps;
            OP_Q:      v = r_q;
            OP_RHOAVG: v = $signed({1'b0, rho_avg});
            OP_C2:     v = r_c2;
            OP_SC:     v = $signed({1'b0, r_pt.sc});
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign m       = rnd(r_p, r_pneg);
    assign dp      = sat34(34'(r_pt.pl) - 34'(r_pt.pr));
    assign dun     = sat34(34'(r_unl) - 34'(r_unr));
    assign rsum    = 32'(r_pt.rhol) + 32'(r_pt.rhor);
    assign rho_avg = rsum[31:1];
    assign zs      = {1'b0, r_zl} + {1'b0, r_zr};
    assign den     = (zs[32:31] != 2'b00) ? 31'h7FFF_FFFF : zs[30:0];
    assign fault   = (den == 31'd0) || (rho_avg == 31'd0);
    assign cs      = {1'b0, r_t} + {1'b0, m};

    always_comb begin
        a_v = pick(ctl.a_sel);
        b_v = pick(ctl.b_sel);
    end
    assign ma   = a_v[31] ? 32'(-a_v) : 32'(a_v);
    assign mb   = b_v[31] ? 32'(-b_v) : 32'(b_v);
    assign prod = 64'(ma) * 64'(mb);

    always_comb begin
        unique case (ctl.dn_sel)
            DN_UNNUM: div_n = r_unnum;
            DN_PNUM:  div_n = r_pnum;
            DN_T:     div_n = r_t;
            default:  div_n = r_t;
        endcase
    end
    assign div_d = ctl.dd_rho ? rho_avg : den;

    arff_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_go),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_M0;
            ST_M0:   n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_M4;
            ST_M4:   n_state = ST_M5;
            ST_M5:   n_state = ST_M6;
            ST_M6:   n_state = ST_CHK;
            ST_CHK:  n_state = fault ? ST_OUT : ST_M8;
            ST_M8:   n_state = ST_M9;
            ST_M9:   n_state = ST_M10;
            ST_M10:  n_state = ST_M11;
            ST_M11:  n_state = ST_M12;
            ST_M12:  n_state = ST_M13;
            ST_M13:  n_state = ST_M14;
            ST_M14:  n_state = ST_D0;
            ST_D0:   if (div_done) n_state = ST_D1;
            ST_D1:   n_state = ST_D1W;
            ST_D1W:  if (div_done) n_state = ST_C0;
            ST_C0:   n_state = ST_C1;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_X0;
            ST_X0:   n_state = ST_X1;
            ST_X1:   n_state = ST_X2;
            ST_X2:   if (div_done) n_state = ST_X3;
            ST_X3:   n_state = ST_X4;
            ST_X4:   n_state = ST_Y0;
            ST_Y0:   n_state = ST_Y1;
            ST_Y1:   n_state = ST_Y2;
            ST_Y2:   if (div_done) n_state = ST_Y3;
            ST_Y3:   n_state = ST_Y4;
            ST_Y4:   n_state = ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   n_state = ST_P2;
            ST_P2:   n_state = ST_P3;
            ST_P3:   n_state = ST_P4;
            ST_P4:   n_state = ST_OUT;
            ST_OUT:  if (!i_out_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control per step: operands issued now, product of the previous step written back
    always_comb begin
        ctl        = '0;
        ctl.a_sel  = OP_T;
        ctl.b_sel  = OP_T;
        ctl.wb     = WB_NONE;
        ctl.dn_sel = DN_T;
        unique case (r_state)
            ST_IDLE: ctl.pop = !i_q_empty;
            ST_M0:   begin ctl.a_sel = OP_RHOL; ctl.b_sel = OP_CL; end
            ST_M1:   begin ctl.wb = WB_ZL; ctl.a_sel = OP_RHOR; ctl.b_sel = OP_CR; end
            ST_M2:   begin ctl.wb = WB_ZR; ctl.a_sel = OP_VXL; ctl.b_sel = OP_NX; end
            ST_M3:   begin ctl.wb = WB_T; ctl.a_sel = OP_VYL; ctl.b_sel = OP_NY; end
            ST_M4:   begin ctl.wb = WB_UNL; ctl.a_sel = OP_VXR; ctl.b_sel = OP_NX; end
            ST_M5:   begin ctl.wb = WB_T; ctl.a_sel = OP_VYR; ctl.b_sel = OP_NY; end
            ST_M6:   ctl.wb = WB_UNR;
            ST_CHK: begin
                if (fault) begin
                    ctl.wb = WB_FAULT;
                end
                ctl.a_sel = OP_ZL;
                ctl.b_sel = OP_UNL;
            end
            ST_M8:   begin ctl.wb = WB_ACC; ctl.a_sel = OP_ZR; ctl.b_sel = OP_UNR; end
            ST_M9:   begin ctl.wb = WB_UNNUM; ctl.a_sel = OP_ZR; ctl.b_sel = OP_PL; end
            ST_M10:  begin ctl.wb = WB_ACC; ctl.a_sel = OP_ZL; ctl.b_sel = OP_PR; end
            ST_M11:  begin ctl.wb = WB_ACCADD; ctl.a_sel = OP_ZL; ctl.b_sel = OP_ZR; end
            ST_M12:  ctl.wb = WB_T;
            ST_M13:  begin ctl.a_sel = OP_T; ctl.b_sel = OP_DUN; end
            ST_M14: begin
                ctl.wb     = WB_PNUM;
                ctl.div_go = 1'b1;
                ctl.dn_sel = DN_UNNUM;
            end
            ST_D0:   if (div_done) ctl.wb = WB_US;
            ST_D1:   begin ctl.div_go = 1'b1; ctl.dn_sel = DN_PNUM; end
            ST_D1W:  if (div_done) ctl.wb = WB_PS;
            ST_C0:   begin ctl.a_sel = OP_CL; ctl.b_sel = OP_CL; end
            ST_C1:   begin ctl.wb = WB_T; ctl.a_sel = OP_CR; ctl.b_sel = OP_CR; end
            ST_C2:   begin ctl.wb = WB_C2; ctl.a_sel = OP_PS; ctl.b_sel = OP_NX; end
            ST_X0:   ctl.wb = WB_T;
            ST_X1:   begin ctl.div_go = 1'b1; ctl.dn_sel = DN_T; ctl.dd_rho = 1'b1; end
            ST_X2:   if (div_done) ctl.wb = WB_Q;
            ST_X3:   begin ctl.a_sel = OP_Q; ctl.b_sel = OP_SC; end
            ST_X4:   begin ctl.wb = WB_FX; ctl.a_sel = OP_PS; ctl.b_sel = OP_NY; end
            ST_Y0:   ctl.wb = WB_T;
            ST_Y1:   begin ctl.div_go = 1'b1; ctl.dn_sel = DN_T; ctl.dd_rho = 1'b1; end
            ST_Y2:   if (div_done) ctl.wb = WB_Q;
            ST_Y3:   begin ctl.a_sel = OP_Q; ctl.b_sel = OP_SC; end
            ST_Y4:   begin ctl.wb = WB_FY; ctl.a_sel = OP_RHOAVG; ctl.b_sel = OP_C2; end
            ST_P0:   ctl.wb = WB_T;
            ST_P1:   begin ctl.a_sel = OP_T; ctl.b_sel = OP_US; end
            ST_P2:   ctl.wb = WB_T;
            ST_P3:   begin ctl.a_sel = OP_T; ctl.b_sel = OP_SC; end
            ST_P4:   ctl.wb = WB_FP;
            ST_OUT:  ctl.push = !i_out_full;
            default: ctl.wb = WB_NONE;
        endcase
    end

    assign o_pop  = ctl.pop;
    assign o_push = ctl.push;
    always_comb begin
        o_res.fx    = r_fx;
        o_res.fy    = r_fy;
        o_res.fp    = r_fp;
        o_res.fault = r_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= prod;
        r_pneg <= a_v[31] ^ b_v[31];
        if (ctl.pop) begin
            r_pt    <= i_pt;
            r_fault <= 1'b0;
        end
        unique case (ctl.wb)
            WB_ZL:     r_zl <= m;
            WB_ZR:     r_zr <= m;
            WB_T:      r_t <= m;
            WB_UNL:    r_unl <= sat34(34'(r_t) + 34'(m));
            WB_UNR:    r_unr <= sat34(34'(r_t) + 34'(m));
            WB_ACC:    r_acc <= 34'(m);
            WB_UNNUM:  r_unnum <= sat34(r_acc + 34'(m) + 34'(dp));
            WB_ACCADD: r_acc <= r_acc + 34'(m);
            WB_PNUM:   r_pnum <= sat34(r_acc + 34'(m));
            WB_C2:     r_c2 <= $signed(cs[32:1]);
            WB_FX:     r_fx <= m;
            WB_FY:     r_fy <= m;
            WB_FP:     r_fp <= m;
            WB_US:     r_us <= div_q;
            WB_PS:     r_ps <= div_q;
            WB_Q:      r_q <= div_q;
            WB_FAULT: begin
                r_fx    <= '0;
                r_fy    <= '0;
                r_fp    <= '0;
                r_fault <= 1'b1;
            end
            default:   r_t <= r_t;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/acoustic_riemann_face_flux_unit.sv
// Upwind interface flux of 2D linear acoustics, one face point at a time.
// Input side is a queue: drive the word on the i_ ports with push high; it is
// taken on a rising edge where full is low. Command 0 stores the exterior state,
// which is held for later points; command 1 brings the interior state, normal and
// face scale and yields one result word (three fluxes and div_fault).
// Result side is a queue: while empty is low the oldest result is on the o_
// ports; pop high takes it on the rising edge.
// Command 0 words set the exterior state in the front. For command 1 words, a
// shared 32x32 multiplier does one product per cycle unless a division is
// awaited, and a shared divider, one quotient bit per cycle, runs four
// divisions per point. A quotient beyond 33 bits skips the bit steps; a point
// with a zero divisor or average density ends at the check step. A two-word
// queue between front and engine and a two-word result queue decouple both
// sides; a stalled receiver holds the engine only once the result queue fills.
// Reset (synchronous, active low) clears the exterior state to zero and empties
// both queues; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module acoustic_riemann_face_flux_unit
    import arff_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic signed [31:0] i_pressure,
    input  wire logic [30:0]        i_sound_speed,
    input  wire logic [30:0]        i_density,
    input  wire logic signed [17:0] i_normal_x,
    input  wire logic signed [17:0] i_normal_y,
    input  wire logic [30:0]        i_face_scale,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_flux_vel_x,
    output logic signed [31:0]      o_flux_vel_y,
    output logic signed [31:0]      o_flux_pressure,
    output logic                    o_div_fault
);

    logic           q_full;
    logic           q_empty;
    logic           enq;
    t_pt            f_pt;
    logic [PT_W-1:0] q_data;
    t_pt            b_pt;
    logic           b_pop;
    logic           out_full;
    logic           b_push;
    t_res           b_res;
    logic [RES_W-1:0] r_data;
    t_res           res;

    arff_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_pressure    (i_pressure),
        .i_sound_speed (i_sound_speed),
        .i_density     (i_density),
        .i_normal_x    (i_normal_x),
        .i_normal_y    (i_normal_y),
        .i_face_scale  (i_face_scale),
        .i_q_full      (q_full),
        .o_enq         (enq),
        .o_pt          (f_pt)
    );

    arff_fifo #(
        .W(PT_W)
    ) u_ptq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  (f_pt),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign b_pt = t_pt'(q_data);

    arff_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_pt       (b_pt),
        .o_pop      (b_pop),
        .i_out_full (out_full),
        .o_push     (b_push),
        .o_res      (b_res)
    );

    arff_fifo #(
        .W(RES_W)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (r_data),
        .o_empty (empty)
    );

    assign res             = t_res'(r_data);
    assign o_flux_vel_x    = res.fx;
    assign o_flux_vel_y    = res.fy;
    assign o_flux_pressure = res.fp;
    assign o_div_fault     = res.fault;

endmodule

`default_nettype wire

FILE: dv/acoustic_riemann_face_flux_unit_tb.sv
`timescale 1ns / 1ps

module acoustic_riemann_face_flux_unit_tb;
    import arff_pkg::*;

    localparam int FB = 16;
    localparam int N_RANDOM = 530;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic               cmd;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] p;
        logic [30:0]        c;
        logic [30:0]        rho;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0]        sc;
        bit                 fixed;
        t_res               fixed_res;
    } t_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               i_command = 1'b0;
    logic signed [31:0] i_vel_x = '0;
    logic signed [31:0] i_vel_y = '0;
    logic signed [31:0] i_pressure = '0;
    logic [30:0]        i_sound_speed = '0;
    logic [30:0]        i_density = '0;
    logic signed [17:0] i_normal_x = '0;
    logic signed [17:0] i_normal_y = '0;
    logic [30:0]        i_face_scale = '0;
    logic               full;
    logic               empty;
    logic signed [31:0] o_flux_vel_x;
    logic signed [31:0] o_flux_vel_y;
    logic signed [31:0] o_flux_pressure;
    logic               o_div_fault;

    t_word  words[$];
    t_res   flux_due[$];
    longint ext_vx, ext_vy, ext_p, ext_c, ext_rho;
    int     errors = 0;
    int     idle_cycles = 0;
    int     n_results = 0;

    acoustic_riemann_face_flux_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_pressure      (i_pressure),
        .i_sound_speed   (i_sound_speed),
        .i_density       (i_density),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_face_scale    (i_face_scale),
        .empty           (empty),
        .pop             (pop),
        .o_flux_vel_x    (o_flux_vel_x),
        .o_flux_vel_y    (o_flux_vel_y),
        .o_flux_pressure (o_flux_pressure),
        .o_div_fault     (o_div_fault)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed_clamp(longint unsigned m, bit neg);
        longint s;
        if (m > (64'd1 << 40)) m = 64'd1 << 40;
        s = longint'(m);
        return sat32(neg ? -s : s);
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned pr;
        pr = mag(a) * mag(b);
        pr = (pr + (64'd1 << (FB - 1))) >> FB;
        return signed_clamp(pr, (a < 0) != (b < 0));
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint unsigned dm, q;
        dm = mag(d);
        if (dm == 0) return 0;
        q = ((mag(n) << FB) + dm / 2) / dm;
        return signed_clamp(q, (n < 0) != (d < 0));
    endfunction

    // interior word against the held exterior state
    function automatic t_res face_flux(t_word w);
        longint vx, vy, p, c, rho, nx, ny, sc;
        longint rho_avg, c2_avg, zl, zr, unl, unr, den, un_num, p_num, us, ps;
        t_res r;
        vx = w.vx; vy = w.vy; p = w.p; c = w.c; rho = w.rho;
        nx = w.nx; ny = w.ny; sc = w.sc;
        rho_avg = sat32((rho + ext_rho) / 2);
        zl = qmul(rho, c);
        zr = qmul(ext_rho, ext_c);
        unl = sat32(qmul(vx, nx) + qmul(vy, ny));
        unr = sat32(qmul(ext_vx, nx) + qmul(ext_vy, ny));
        den = sat32(zl + zr);
        r = '0;
        if (den == 0 || rho_avg == 0) begin
            r.fault = 1'b1;
            return r;
        end
        un_num = sat32(qmul(zl, unl) + qmul(zr, unr) + sat32(p - ext_p));
        p_num = sat32(qmul(zr, p) + qmul(zl, ext_p) + qmul(qmul(zl, zr), sat32(unl - unr)));
        us = qdiv(un_num, den);
        ps = qdiv(p_num, den);
        c2_avg = sat32((qmul(c, c) + qmul(ext_c, ext_c)) / 2);
        r.fx = 32'(qmul(qdiv(qmul(ps, nx), rho_avg), sc));
        r.fy = 32'(qmul(qdiv(qmul(ps, ny), rho_avg), sc));
        r.fp = 32'(qmul(qmul(qmul(rho_avg, c2_avg), us), sc));
        return r;
    endfunction

    function automatic t_word mk(logic cmd, logic [31:0] vx, logic [31:0] vy,
                                 logic [31:0] p, logic [30:0] c, logic [30:0] rho,
                                 logic [17:0] nx, logic [17:0] ny, logic [30:0] sc);
        t_word w;
        w.cmd = cmd; w.vx = vx; w.vy = vy; w.p = p; w.c = c; w.rho = rho;
        w.nx = nx; w.ny = ny; w.sc = sc; w.fixed = 1'b0; w.fixed_res = '0;
        return w;
    endfunction

    function automatic t_word mk_fault(t_word w);
        w.fixed = 1'b1;
        w.fixed_res = '{fx: 32'sd0, fy: 32'sd0, fp: 32'sd0, fault: 1'b1};
        return w;
    endfunction

    function automatic logic [31:0] rnd_sig();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    function automatic logic [30:0] rnd_pos();
        case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1: return '0;
            default: return 31'($urandom_range(1 << 13, 4 << 16));
        endcase
    endfunction

    function automatic logic [17:0] rnd_normal();
        if ($urandom_range(0, 7) == 0) return 18'($urandom);
        return 18'($urandom_range(0, 1 << 17)) - 18'(1 << 16);
    endfunction

    function automatic t_word rnd_word(logic cmd);
        return mk(cmd, rnd_sig(), rnd_sig(), rnd_sig(), rnd_pos(), rnd_pos(),
                  rnd_normal(), rnd_normal(), rnd_pos());
    endfunction

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** acoustic_riemann_face_flux_unit: FAILED **");
            $finish;
        end
    end

    // receiver
    initial begin
        int gap;
        t_res got, want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (n_results == 60) gap = HOLD_CYCLES;
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            n_results++;
            got = '{fx: o_flux_vel_x, fy: o_flux_vel_y, fp: o_flux_pressure,
                    fault: o_div_fault};
            if (flux_due.size() == 0) begin
                $display("%0t: unexpected result word fx=%h fy=%h fp=%h fault=%b",
                         $time, got.fx, got.fy, got.fp, got.fault);
                errors++;
            end else begin
                want = flux_due.pop_front();
                if (got.fx !== want.fx) begin
                    $display("%0t: flux_vel_x expected %h actual %h", $time, want.fx, got.fx);
                    errors++;
                end
                if (got.fy !== want.fy) begin
                    $display("%0t: flux_vel_y expected %h actual %h", $time, want.fy, got.fy);
                    errors++;
                end
                if (got.fp !== want.fp) begin
                    $display("%0t: flux_pressure expected %h actual %h",
                             $time, want.fp, got.fp);
                    errors++;
                end
                if (got.fault !== want.fault) begin
                    $display("%0t: div_fault expected %b actual %b",
                             $time, want.fault, got.fault);
                    errors++;
                end
            end
        end
    end

    // sender
    initial begin
        int gap, tail;
        t_word w;
        ext_vx = 0; ext_vy = 0; ext_p = 0; ext_c = 0; ext_rho = 0;

        // directed words
        words.push_back(mk_fault(mk(CMD_INT, 0, 0, 0, 0, 0, 0, 0, 0)));
        words.push_back(mk(CMD_EXT, 32'h0001_0000, 32'hffff_8000, 32'h0002_0000,
                           31'h0001_0000, 31'h0001_0000, 0, 0, 0));
        words.push_back(mk(CMD_INT, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000,
                           31'h0002_0000, 31'h0001_8000, 18'h10000, 18'h00000,
                           31'h0001_0000));
        words.push_back(mk(CMD_EXT, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           31'h7fff_ffff, 31'h7fff_ffff, 0, 0, 0));
        words.push_back(mk(CMD_INT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                           31'h7fff_ffff, 31'h7fff_ffff, 18'h30000, 18'h10000,
                           31'h7fff_ffff));
        words.push_back(mk(CMD_INT, 32'h0003_0000, 32'hfffd_0000, 32'h0000_4000,
                           31'h0000_0001, 31'h0000_0001, 18'h0b505, 18'h34afb,
                           31'h0000_0001));
        words.push_back(mk(CMD_EXT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                           0, 0, 0, 0, 0));
        words.push_back(mk_fault(mk(CMD_INT, 32'h0001_0000, 0, 0, 0, 0,
                                    18'h10000, 0, 31'h0001_0000)));
        words.push_back(mk_fault(mk(CMD_INT, 32'h0001_0000, 0, 0, 0, 31'h0000_0005,
                                    18'h10000, 0, 31'h0001_0000)));
        words.push_back(mk(CMD_INT, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                           31'h0001_0000, 31'h0002_0000, 0, 18'h10000, 31'h0002_0000));
        words.push_back(mk(CMD_INT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                           31'h0001_0000, 31'h0001_0000, 18'h1ffff, 18'h20000,
                           31'h0001_0000));
        words.push_back(mk(CMD_EXT, 32'hffff_ffff, 32'h0000_0001, 32'hffff_0000,
                           31'h0000_0001, 31'h0000_0001, 0, 0, 0));
        words.push_back(mk(CMD_INT, 32'h0000_0001, 32'hffff_ffff, 32'h0001_0000,
                           31'h0000_0001, 31'h0000_0001, 18'h10000, 18'h30000,
                           31'h7fff_ffff));
        words.push_back(mk(CMD_EXT, 32'h0000_4000, 32'h0000_2000, 32'h0000_1000,
                           31'h0000_2000, 31'h0000_4000, 0, 0, 0));
        words.push_back(mk(CMD_INT, 32'hffff_c000, 32'hffff_e000, 32'hffff_f000,
                           31'h0000_2000, 31'h0000_4000, 18'h3b505, 18'h0b505,
                           31'h0000_8000));

        // random words, mostly exterior/interior pairs
        while (words.size() < N_RANDOM + 15) begin
            if ($urandom_range(0, 9) < 8) begin
                words.push_back(rnd_word(CMD_EXT));
                words.push_back(rnd_word(CMD_INT));
            end else begin
                words.push_back(rnd_word($urandom_range(0, 1) ? CMD_INT : CMD_EXT));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (words[k]) begin
            w = words[k];
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push          <= 1'b1;
            i_command     <= w.cmd;
            i_vel_x       <= w.vx;
            i_vel_y       <= w.vy;
            i_pressure    <= w.p;
            i_sound_speed <= w.c;
            i_density     <= w.rho;
            i_normal_x    <= w.nx;
            i_normal_y    <= w.ny;
            i_face_scale  <= w.sc;
            do @(posedge i_clk); while (full);
            if (w.cmd == CMD_EXT) begin
                ext_vx = w.vx; ext_vy = w.vy; ext_p = w.p;
                ext_c = w.c; ext_rho = w.rho;
            end else if (w.fixed) begin
                flux_due.push_back(w.fixed_res);
            end else begin
                flux_due.push_back(face_flux(w));
            end
        end
        push <= 1'b0;

        wait (flux_due.size() == 0);
        tail = 0;
        while (tail < 400) begin
            @(posedge i_clk);
            tail++;
        end
        if (errors == 0)
            $display("** acoustic_riemann_face_flux_unit: PASSED **");
        else
            $display("** acoustic_riemann_face_flux_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/arff_pkg.sv
rtl/arff_fifo.sv
rtl/arff_front.sv
rtl/arff_div.sv
rtl/arff_back.sv
rtl/acoustic_riemann_face_flux_unit.sv
dv/acoustic_riemann_face_flux_unit_tb.sv
